### rtl/dleb_pkg.sv
// ----------------------------------------------------------------------------
// dleb_pkg
// Shared types, constants and helpers of the diagonal luma edge blend filter.
// ----------------------------------------------------------------------------
package dleb_pkg;

  // frame limits and line store geometry
  localparam int unsigned MAX_WIDTH   = 1024;
  localparam int unsigned MAX_HEIGHT  = 1024;
  localparam int unsigned STORE_DEPTH = 2 * MAX_WIDTH + 2;
  localparam int unsigned PTR_W       = $clog2(STORE_DEPTH);

  // field and counter widths
  localparam int unsigned DIM_W  = 11;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned SUM_W  = 11;
  localparam int unsigned THR_W  = 9;
  localparam int unsigned CFG_W  = 11;
  localparam int unsigned PROD_W = 17;

  // pixel outside the frame: black, opaque
  localparam logic [31:0] OUTSIDE_PIXEL = 32'hFF00_0000;

  // luma weights, Q8
  localparam logic [15:0] LUMA_R = 16'd77;
  localparam logic [15:0] LUMA_G = 16'd150;
  localparam logic [15:0] LUMA_B = 16'd29;

  // divide by five: (sum * 3277) >> 14 is exact for sums below 1300
  localparam int unsigned RECIP5_SHIFT = 14;
  localparam int unsigned RECIP5_W     = 23;
  localparam logic [RECIP5_W-1:0] RECIP5 = RECIP5_W'(3277);

  // register reset values
  localparam logic [THR_W-1:0] EDGE_THRESHOLD_RST = THR_W'(32);
  localparam logic [7:0]       EDGE_FLOOR_RST     = 8'd8;
  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST    = DIM_W'(640);
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST   = DIM_W'(480);

  typedef logic [31:0] pixel_t;

  typedef enum logic [1:0] {
    CFG_EDGE_THRESHOLD = 2'd0,
    CFG_EDGE_FLOOR     = 2'd1,
    CFG_FRAME_WIDTH    = 2'd2,
    CFG_FRAME_HEIGHT   = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    FUNC_PIXEL = 1'b0,
    FUNC_FLUSH = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_B,
    ST_READ_C,
    ST_WRITE,
    ST_LUMA,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  // luma of one pixel, (77r + 150g + 29b) >> 8
  function automatic logic [7:0] luma_of(pixel_t px);
    logic [15:0] acc;
    acc = LUMA_R * {8'd0, px[7:0]} + LUMA_G * {8'd0, px[15:8]}
        + LUMA_B * {8'd0, px[23:16]};
    return acc[15:8];
  endfunction

  // ring position k entries behind ptr, k in 1..STORE_DEPTH
  function automatic logic [PTR_W-1:0] ring_back(logic [PTR_W-1:0] ptr,
                                                 logic [PTR_W-1:0] k);
    logic [PTR_W:0] t;
    t = {1'b0, ptr} + (PTR_W + 1)'(STORE_DEPTH) - {1'b0, k};
    if (t >= (PTR_W + 1)'(STORE_DEPTH)) begin
      t = t - (PTR_W + 1)'(STORE_DEPTH);
    end
    return t[PTR_W-1:0];
  endfunction

endpackage

### rtl/dleb_ram.sv
// ----------------------------------------------------------------------------
// dleb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dleb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2050,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/diagonal_luma_edge_blend_filter.sv
// ----------------------------------------------------------------------------
// diagonal_luma_edge_blend_filter
// Edge-aware five-tap diagonal blend over a raster-order RGBA8 stream.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) takes one pixel per transaction in
// raster order; func_i marks flush ticks that drain the last width+1 results
// after the frame's last pixel. Output channel (out_valid_o / out_stall_i)
// gives one filtered pixel with its column and row, lagging the input by
// frame_width+1 transactions. Configuration writes (cfg_valid_i / cfg_ready_o)
// are always taken and must only happen while the block is idle.
// Sequence: an item that yields a result goes through three line store reads,
// the write-back and the three compute stages luma, decide and emit, emit
// loading the result; an item that yields none returns to idle after the
// write-back; a flush tick arriving before frame end is dropped while idle.
// The reads share the single read port of the line store, one per cycle.
// A finished result waits in the output register while the next item is
// accepted; only the final stage waits when the receiver stalls.
// Reset returns configuration registers to defaults and clears all counters;
// the line store is not cleared and is used only where it was written.
// ----------------------------------------------------------------------------
module diagonal_luma_edge_blend_filter (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [dleb_pkg::CFG_W-1:0] cfg_data_i,
  // input pixels
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     func_i,
  input  logic [7:0]               in_red_i,
  input  logic [7:0]               in_green_i,
  input  logic [7:0]               in_blue_i,
  input  logic [7:0]               in_alpha_i,
  // output pixels
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [7:0]               out_red_o,
  output logic [7:0]               out_green_o,
  output logic [7:0]               out_blue_o,
  output logic [7:0]               out_alpha_o,
  output logic [dleb_pkg::POS_W-1:0] out_column_o,
  output logic [dleb_pkg::POS_W-1:0] out_row_o,
  output logic                     was_blended_o,
  output logic                     frame_last_o
);
  import dleb_pkg::*;

  // configuration registers
  logic [THR_W-1:0] edge_threshold_q;
  logic [7:0]       edge_floor_q;
  logic [DIM_W-1:0] frame_width_q;
  logic [DIM_W-1:0] frame_height_q;

  // control state
  state_e           state_q, state_d;
  logic [PTR_W-1:0] store_ptr_q;
  logic [POS_W-1:0] in_column_q;
  logic [DIM_W-1:0] in_row_q;
  logic [POS_W-1:0] out_col_q;
  logic [POS_W-1:0] out_row_q;
  logic [CNT_W-1:0] pending_q;
  logic             out_valid_q;

  // item registers
  pixel_t           cur_q;
  logic             is_pixel_q, produce_q, last_q;
  logic             left_q, right_q, up_q, down_q;
  logic [POS_W-1:0] ox_q, oy_q;
  pixel_t           hist1_q, hist2_q;
  pixel_t           px0_q, px1_q, px3_q, px4_q;
  logic [7:0]       luma_q [5];
  logic [SUM_W-1:0] sum_q [4];
  logic [7:0]       range_q;
  logic [PROD_W-1:0] prod_q;
  logic [7:0]       avg_q [4];

  // output registers
  logic [7:0]       res_q [4];
  logic [POS_W-1:0] res_col_q, res_row_q;
  logic             res_blend_q, res_last_q;

  // combinational
  logic [DIM_W-1:0] w_eff, h_eff;
  logic             cfg_fire, in_fire, out_fire;
  logic             taking, ignored, start, is_pixel;
  logic             produce, left, right, up, down, last;
  pixel_t           cur;
  logic [PTR_W-1:0] k_a, k_b, k_c;
  logic [PTR_W-1:0] raddr;
  logic             ram_we;
  pixel_t           rdata;
  logic             emit_load;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign out_fire    = out_valid_q & ~out_stall_i;

  // clamped frame size
  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (frame_width_q > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width_q;
    end
    if (frame_height_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (frame_height_q > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height_q;
    end
  end

  // item classification and neighbor availability
  always_comb begin
    taking   = in_row_q < h_eff;
    ignored  = (func_e'(func_i) == FUNC_FLUSH) && taking;
    is_pixel = (func_e'(func_i) == FUNC_PIXEL) && taking;
    start    = in_fire && !ignored;
    cur      = is_pixel ? {in_alpha_i, in_blue_i, in_green_i, in_red_i} : OUTSIDE_PIXEL;
    produce  = {1'b0, pending_q} >= ({1'b0, w_eff} + (CNT_W + 1)'(1));
    left     = out_col_q != '0;
    up       = out_row_q != '0;
    right    = ({1'b0, out_col_q} + DIM_W'(1)) < w_eff;
    down     = ({1'b0, out_row_q} + DIM_W'(1)) < h_eff;
    last     = (({1'b0, out_col_q} + DIM_W'(1)) >= w_eff)
            && (({1'b0, out_row_q} + DIM_W'(1)) >= h_eff);
  end

  // line store distances: center, upper right, upper left
  assign k_a = PTR_W'(w_eff) + PTR_W'(1);
  assign k_b = PTR_W'({w_eff, 1'b0});
  assign k_c = PTR_W'({w_eff, 1'b0}) + PTR_W'(2);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_READ_B;
        end
      end
      ST_READ_B: state_d = ST_READ_C;
      ST_READ_C: state_d = ST_WRITE;
      ST_WRITE:  state_d = produce_q ? ST_LUMA : ST_IDLE;
      ST_LUMA:   state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // state outputs: stall, memory control
  always_comb begin
    in_stall_o = 1'b1;
    ram_we     = 1'b0;
    raddr      = ring_back(store_ptr_q, k_a);
    emit_load  = 1'b0;
    case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_READ_B: raddr = ring_back(store_ptr_q, k_b);
      ST_READ_C: raddr = ring_back(store_ptr_q, k_c);
      ST_WRITE:  ram_we = 1'b1;
      ST_EMIT:   emit_load = !out_valid_q || !out_stall_i;
      default:   ;
    endcase
  end

  // line store
  dleb_ram #(
    .WIDTH (32),
    .DEPTH (STORE_DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (store_ptr_q),
    .wdata_i (cur_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_threshold_q <= EDGE_THRESHOLD_RST;
      edge_floor_q     <= EDGE_FLOOR_RST;
      frame_width_q    <= FRAME_WIDTH_RST;
      frame_height_q   <= FRAME_HEIGHT_RST;
    end else if (cfg_fire) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_EDGE_THRESHOLD: edge_threshold_q <= cfg_data_i[THR_W-1:0];
        CFG_EDGE_FLOOR:     edge_floor_q     <= cfg_data_i[7:0];
        CFG_FRAME_WIDTH:    frame_width_q    <= cfg_data_i[DIM_W-1:0];
        CFG_FRAME_HEIGHT:   frame_height_q   <= cfg_data_i[DIM_W-1:0];
        default:            ;
      endcase
    end
  end

  // control state and position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [DIM_W-1:0] col_n;
    logic [DIM_W-1:0] ocol_n;
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      store_ptr_q <= '0;
      in_column_q <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      pending_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_WRITE) begin
        col_n  = {1'b0, in_column_q} + DIM_W'(1);
        ocol_n = {1'b0, out_col_q} + DIM_W'(1);
        store_ptr_q <= (store_ptr_q == PTR_W'(STORE_DEPTH - 1)) ? '0
                     : store_ptr_q + PTR_W'(1);
        if (produce_q && last_q) begin
          in_column_q <= '0;
          in_row_q    <= '0;
          out_col_q   <= '0;
          out_row_q   <= '0;
          pending_q   <= '0;
        end else begin
          if (is_pixel_q) begin
            if (col_n >= w_eff) begin
              in_column_q <= '0;
              in_row_q    <= in_row_q + DIM_W'(1);
            end else begin
              in_column_q <= col_n[POS_W-1:0];
            end
          end
          if (!produce_q) begin
            pending_q <= pending_q + CNT_W'(1);
          end else if (ocol_n >= w_eff) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + POS_W'(1);
          end else begin
            out_col_q <= ocol_n[POS_W-1:0];
          end
        end
      end
    end
  end

  // item capture and memory read captures
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      cur_q      <= cur;
      is_pixel_q <= is_pixel;
      produce_q  <= produce;
      last_q     <= last;
      left_q     <= left;
      right_q    <= right;
      up_q       <= up;
      down_q     <= down;
      ox_q       <= out_col_q;
      oy_q       <= out_row_q;
    end
    if (state_q == ST_READ_B) begin
      px0_q <= rdata;
      px1_q <= hist2_q;
    end
    if (state_q == ST_READ_C) begin
      px4_q <= rdata;
    end
    if (state_q == ST_WRITE) begin
      px3_q   <= rdata;
      hist1_q <= cur_q;
      hist2_q <= hist1_q;
    end
  end

  // luma of the five taps and channel sums
  pixel_t tap [5];
  always_comb begin
    tap[0] = px0_q;
    tap[1] = (left_q && down_q) ? px1_q : OUTSIDE_PIXEL;
    tap[2] = (right_q && down_q) ? cur_q : OUTSIDE_PIXEL;
    tap[3] = (left_q && up_q) ? px3_q : OUTSIDE_PIXEL;
    tap[4] = (right_q && up_q) ? px4_q : OUTSIDE_PIXEL;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LUMA) begin
      for (int i = 0; i < 5; i++) begin
        luma_q[i] <= luma_of(tap[i]);
      end
      for (int c = 0; c < 4; c++) begin
        sum_q[c] <= SUM_W'(2) + SUM_W'(tap[0][8*c +: 8]) + SUM_W'(tap[1][8*c +: 8])
                  + SUM_W'(tap[2][8*c +: 8]) + SUM_W'(tap[3][8*c +: 8])
                  + SUM_W'(tap[4][8*c +: 8]);
      end
    end
  end

  // luma range, relative threshold product and five-way averages
  logic [7:0]          lmax, lmin;
  logic [RECIP5_W-1:0] avg_full [4];
  always_comb begin
    lmax = luma_q[0];
    lmin = luma_q[0];
    for (int i = 1; i < 5; i++) begin
      if (luma_q[i] > lmax) lmax = luma_q[i];
      if (luma_q[i] < lmin) lmin = luma_q[i];
    end
    for (int c = 0; c < 4; c++) begin
      avg_full[c] = RECIP5_W'(sum_q[c]) * RECIP5;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DECIDE) begin
      range_q <= lmax - lmin;
      prod_q  <= PROD_W'(lmax) * PROD_W'(edge_threshold_q);
      for (int c = 0; c < 4; c++) begin
        avg_q[c] <= avg_full[c][RECIP5_SHIFT +: 8];
      end
    end
  end

  // edge decision and output register
  logic [THR_W-1:0] thr_rel, thr;
  logic             blend;
  always_comb begin
    thr_rel = prod_q[PROD_W-1:8];
    thr     = (thr_rel < {1'b0, edge_floor_q}) ? {1'b0, edge_floor_q} : thr_rel;
    blend   = {1'b0, range_q} >= thr;
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      for (int c = 0; c < 4; c++) begin
        res_q[c] <= blend ? avg_q[c] : px0_q[8*c +: 8];
      end
      res_col_q   <= ox_q;
      res_row_q   <= oy_q;
      res_blend_q <= blend;
      res_last_q  <= last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_red_o     = res_q[0];
  assign out_green_o   = res_q[1];
  assign out_blue_o    = res_q[2];
  assign out_alpha_o   = res_q[3];
  assign out_column_o  = res_col_q;
  assign out_row_o     = res_row_q;
  assign was_blended_o = res_blend_q;
  assign frame_last_o  = res_last_q;

endmodule

### rtl/dleb_checker.sv
// ----------------------------------------------------------------------------
// dleb_checker
// Port-level checks of the diagonal luma edge blend filter, bound to the top.
// ----------------------------------------------------------------------------
module dleb_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     func_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [7:0]               out_red_o,
  input logic [7:0]               out_green_o,
  input logic [7:0]               out_blue_o,
  input logic [7:0]               out_alpha_o,
  input logic [dleb_pkg::POS_W-1:0] out_column_o,
  input logic [dleb_pkg::POS_W-1:0] out_row_o,
  input logic                     was_blended_o,
  input logic                     frame_last_o
);
  import dleb_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn under stall");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable({out_red_o, out_green_o, out_blue_o,
      out_alpha_o, out_column_o, out_row_o, was_blended_o, frame_last_o}))
    else $error("result payload changed under stall");

  // a pixel transaction always starts an item, which keeps the input stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (func_e'(func_i) == FUNC_PIXEL) |=> in_stall_o)
    else $error("input accepted again right after a pixel");

  // a new result is only loaded from the final compute stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while input side was idle");

endmodule

bind diagonal_luma_edge_blend_filter dleb_checker u_dleb_checker (.*);

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the diagonal luma edge blend filter. A short walk
// through hand-written frames comes first, then random frames of random size
// and thresholds, a wide frame under a long output hold-off, a one-column
// frame and a frame with out-of-range sizes. Every accepted output pixel is
// compared with a hand-set value or a cycle-free software copy of the filter.
// ----------------------------------------------------------------------------
module tb_top;
  import dleb_pkg::*;

  localparam int unsigned RESET_CYCLES  = 10;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int unsigned ITEM_TARGET   = 600;
  localparam int unsigned TAIL_ITEMS    = 160;

  // one output pixel as seen on the result port
  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic             blended;
    logic             last;
  } blend_out_t;

  // one line of the directed stimulus table
  typedef struct {
    bit               is_cfg;
    cfg_idx_e         idx;
    logic [CFG_W-1:0] data;
    func_e            func;
    pixel_t           px;
    bit               typed;
    blend_out_t       want;
  } stim_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i  = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic             func_i      = 1'b0;
  logic [7:0]       in_red_i    = '0;
  logic [7:0]       in_green_i  = '0;
  logic [7:0]       in_blue_i   = '0;
  logic [7:0]       in_alpha_i  = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [7:0]       out_red_o;
  logic [7:0]       out_green_o;
  logic [7:0]       out_blue_o;
  logic [7:0]       out_alpha_o;
  logic [POS_W-1:0] out_column_o;
  logic [POS_W-1:0] out_row_o;
  logic             was_blended_o;
  logic             frame_last_o;

  int unsigned mismatches    = 0;
  int unsigned items_counted = 0;
  int unsigned burst_left    = 0;
  int unsigned cycle_count   = 0;
  bit          hold_request  = 1'b0;
  blend_out_t  expected_pixels[$];
  stim_row_t   directed_plan[$];

  // shadow copy of the filter state and registers
  pixel_t      line_mem [STORE_DEPTH];
  int unsigned wr_ptr     = 0;
  int unsigned in_col     = 0;
  int unsigned in_row     = 0;
  int unsigned out_col    = 0;
  int unsigned out_row    = 0;
  int unsigned pending    = 0;
  int unsigned thr_cfg    = 32;
  int unsigned floor_cfg  = 8;
  int unsigned width_cfg  = 640;
  int unsigned height_cfg = 480;

  diagonal_luma_edge_blend_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .in_red_i      (in_red_i),
    .in_green_i    (in_green_i),
    .in_blue_i     (in_blue_i),
    .in_alpha_i    (in_alpha_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_red_o     (out_red_o),
    .out_green_o   (out_green_o),
    .out_blue_o    (out_blue_o),
    .out_alpha_o   (out_alpha_o),
    .out_column_o  (out_column_o),
    .out_row_o     (out_row_o),
    .was_blended_o (was_blended_o),
    .frame_last_o  (frame_last_o)
  );

  // 8 ns clock
  always #4 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("diagonal_luma_edge_blend_filter regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // filter prediction
  // ---------------------------------------------------------------------------

  function automatic int unsigned eff_width();
    return (width_cfg < 1) ? 1 : ((width_cfg > MAX_WIDTH) ? MAX_WIDTH : width_cfg);
  endfunction

  function automatic int unsigned eff_height();
    return (height_cfg < 1) ? 1 : ((height_cfg > MAX_HEIGHT) ? MAX_HEIGHT : height_cfg);
  endfunction

  function automatic int unsigned pixel_luma(pixel_t p);
    return (77 * p[7:0] + 150 * p[15:8] + 29 * p[23:16]) >> 8;
  endfunction

  // pixel stored k transactions ago
  function automatic pixel_t line_ago(int unsigned k);
    return line_mem[(wr_ptr + STORE_DEPTH - (k % STORE_DEPTH)) % STORE_DEPTH];
  endfunction

  function automatic void apply_cfg(cfg_idx_e idx, logic [CFG_W-1:0] d);
    case (idx)
      CFG_EDGE_THRESHOLD: thr_cfg = d[8:0];
      CFG_EDGE_FLOOR:     floor_cfg = d[7:0];
      CFG_FRAME_WIDTH:    width_cfg = d;
      CFG_FRAME_HEIGHT:   height_cfg = d;
      default: ;
    endcase
  endfunction

  // advance the shadow state by one accepted transaction, 1 if it gives a pixel
  function automatic bit predict_blend(input func_e f, input pixel_t px_in,
                                       output blend_out_t o);
    int unsigned w, h, ox, oy, lmin, lmax, l, limit, sum, i, c;
    bit          taking, is_pixel, produce, left, right, up, down, blended, last;
    pixel_t      cur, res;
    pixel_t      tap [5];
    o = '0;
    w = eff_width();
    h = eff_height();
    taking = in_row < h;
    blended = 1'b0;
    last = 1'b0;
    res = '0;
    // flush while the frame still wants pixels does nothing
    if (f == FUNC_FLUSH && taking) begin
      return 1'b0;
    end
    is_pixel = (f == FUNC_PIXEL) && taking;
    cur = is_pixel ? px_in : OUTSIDE_PIXEL;
    produce = pending >= w + 1;
    ox = out_col;
    oy = out_row;

    if (produce) begin
      left  = ox >= 1;
      right = ox + 1 < w;
      up    = oy >= 1;
      down  = oy + 1 < h;
      tap[0] = line_ago(w + 1);
      tap[1] = (left && down) ? line_ago(2) : OUTSIDE_PIXEL;
      tap[2] = (right && down) ? cur : OUTSIDE_PIXEL;
      tap[3] = (left && up) ? line_ago(2 * w + 2) : OUTSIDE_PIXEL;
      tap[4] = (right && up) ? line_ago(2 * w) : OUTSIDE_PIXEL;
      lmin = pixel_luma(tap[0]);
      lmax = lmin;
      for (i = 1; i < 5; i++) begin
        l = pixel_luma(tap[i]);
        if (l < lmin) lmin = l;
        if (l > lmax) lmax = l;
      end
      limit = (lmax * thr_cfg) >> 8;
      if (limit < floor_cfg) limit = floor_cfg;
      if (lmax - lmin < limit) begin
        res = tap[0];
      end else begin
        blended = 1'b1;
        for (c = 0; c < 4; c++) begin
          sum = 2;
          for (i = 0; i < 5; i++) sum += tap[i][8*c +: 8];
          res[8*c +: 8] = 8'(sum / 5);
        end
      end
      last = (ox + 1 >= w) && (oy + 1 >= h);
    end

    line_mem[wr_ptr] = cur;
    wr_ptr = (wr_ptr + 1) % STORE_DEPTH;

    if (is_pixel) begin
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    end

    if (!produce) begin
      pending++;
      return 1'b0;
    end

    o.red     = res[7:0];
    o.green   = res[15:8];
    o.blue    = res[23:16];
    o.alpha   = res[31:24];
    o.column  = ox[POS_W-1:0];
    o.row     = oy[POS_W-1:0];
    o.blended = blended;
    o.last    = last;

    // frame done: all counters start over
    if (last) begin
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
      pending = 0;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  // pixel near a frame base color, fully random, or saturated channels
  function automatic pixel_t make_pixel(pixel_t base);
    pixel_t p;
    int     v;
    int     c;
    case ($urandom_range(0, 3))
      0, 1: begin
        for (c = 0; c < 4; c++) begin
          v = int'(base[8*c +: 8]) + int'($urandom_range(0, 8)) - 4;
          p[8*c +: 8] = (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : v[7:0]);
        end
      end
      2: p = $urandom;
      default: begin
        for (c = 0; c < 4; c++) p[8*c +: 8] = {8{1'($urandom_range(0, 1))}};
      end
    endcase
    return p;
  endfunction

  function automatic blend_out_t lone_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                            logic [7:0] a, logic blended);
    blend_out_t o;
    o = '0;
    o.red = r;
    o.green = g;
    o.blue = b;
    o.alpha = a;
    o.blended = blended;
    o.last = 1'b1;
    return o;
  endfunction

  function automatic void plan_cfg(cfg_idx_e idx, logic [CFG_W-1:0] d);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = d;
    row.func   = FUNC_PIXEL;
    row.px     = '0;
    row.typed  = 1'b0;
    row.want   = '0;
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_item(func_e f, pixel_t px, bit typed, blend_out_t want);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.idx    = CFG_EDGE_THRESHOLD;
    row.data   = '0;
    row.func   = f;
    row.px     = px;
    row.typed  = typed;
    row.want   = want;
    directed_plan.push_back(row);
  endfunction

  // one register write transaction, block idle
  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_cfg(idx, d);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_regs(logic [CFG_W-1:0] thr, logic [CFG_W-1:0] flr,
                              logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    write_reg(CFG_EDGE_THRESHOLD, thr);
    write_reg(CFG_EDGE_FLOOR, flr);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
  endtask

  // one input transaction, then a random gap
  task automatic send_item(func_e f, pixel_t px, bit typed, blend_out_t want);
    blend_out_t got;
    bit         hit;
    bit         ignored;
    int unsigned gap;
    in_valid_i <= 1'b1;
    func_i     <= f;
    in_red_i   <= px[7:0];
    in_green_i <= px[15:8];
    in_blue_i  <= px[23:16];
    in_alpha_i <= px[31:24];
    do @(posedge clk_i); while (in_stall_o);
    ignored = (f == FUNC_FLUSH) && (in_row < eff_height());
    hit = predict_blend(f, px, got);
    if (typed) expected_pixels.push_back(want);
    else if (hit) expected_pixels.push_back(got);
    if (!ignored) items_counted++;
    // bursts with no gaps at all now and then
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 149) == 0) burst_left = $urandom_range(30, 120);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // wait for all pixels, then for the last result-less item to finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one whole frame plus its drain ticks, with stray flushes mixed in
  task automatic send_frame(bit hold_in_drain);
    int unsigned w, h, n;
    pixel_t      base;
    w = eff_width();
    h = eff_height();
    base = $urandom;
    for (n = 0; n < w * h; n++) begin
      if ($urandom_range(0, 15) == 0) send_item(FUNC_FLUSH, $urandom, 1'b0, '0);
      send_item(FUNC_PIXEL, make_pixel(base), 1'b0, '0);
    end
    if (hold_in_drain) hold_request = 1'b1;
    // a pixel past the frame end drains like a flush
    for (n = 0; n < w + 1; n++) begin
      if ($urandom_range(0, 3) == 0) send_item(FUNC_PIXEL, $urandom, 1'b0, '0);
      else send_item(FUNC_FLUSH, $urandom, 1'b0, '0);
    end
    if ($urandom_range(0, 3) == 0) send_item(FUNC_FLUSH, $urandom, 1'b0, '0);
  endtask

  // output stall pattern, with one long hold-off on request
  initial begin : out_stall_driver
    int unsigned busy_left;
    int unsigned free_left;
    bit          hold_done;
    busy_left = 0;
    free_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        busy_left = HOLD_CYCLES;
        free_left = 0;
      end
      if (busy_left > 0) begin
        busy_left--;
        out_stall_i <= 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        out_stall_i <= 1'b0;
      end else begin
        busy_left = idle_len();
        free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 160)
                                                : $urandom_range(1, 6);
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [9:0] want, logic [9:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    blend_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        $error("output transaction with nothing pending: column %0d row %0d",
               out_column_o, out_row_o);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("out_red", want.red, out_red_o);
        check_field("out_green", want.green, out_green_o);
        check_field("out_blue", want.blue, out_blue_o);
        check_field("out_alpha", want.alpha, out_alpha_o);
        check_field("out_column", want.column, out_column_o);
        check_field("out_row", want.row, out_row_o);
        check_field("was_blended", want.blended, was_blended_o);
        check_field("frame_last", want.last, frame_last_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    blend_out_t none;
    none = '0;
    foreach (line_mem[i]) line_mem[i] = '0;

    // single-pixel frames whose result is known by hand, reset thresholds
    plan_cfg(CFG_FRAME_WIDTH, 1);
    plan_cfg(CFG_FRAME_HEIGHT, 1);
    plan_item(FUNC_FLUSH, 32'hA5A5_A5A5, 1'b0, none);
    plan_item(FUNC_PIXEL, 32'hFFFF_FFFF, 1'b0, none);
    plan_item(FUNC_PIXEL, 32'h0000_0000, 1'b0, none);
    plan_item(FUNC_FLUSH, 32'h5A5A_5A5A, 1'b1, lone_pixel(51, 51, 51, 255, 1'b1));
    plan_item(FUNC_PIXEL, 32'h0000_0000, 1'b0, none);
    plan_item(FUNC_FLUSH, 32'hFFFF_FFFF, 1'b0, none);
    plan_item(FUNC_FLUSH, 32'h0000_0000, 1'b1, lone_pixel(0, 0, 0, 0, 1'b0));
    // zero thresholds: a flat black pixel still blends with the border
    plan_cfg(CFG_EDGE_THRESHOLD, 0);
    plan_cfg(CFG_EDGE_FLOOR, 0);
    plan_item(FUNC_PIXEL, 32'h0000_0000, 1'b0, none);
    plan_item(FUNC_FLUSH, 32'h0000_0000, 1'b0, none);
    plan_item(FUNC_FLUSH, 32'h0000_0000, 1'b1, lone_pixel(0, 0, 0, 204, 1'b1));
    // relative threshold beyond 1.0 and top floor: nothing counts as an edge
    plan_cfg(CFG_EDGE_THRESHOLD, 511);
    plan_cfg(CFG_EDGE_FLOOR, 255);
    plan_item(FUNC_PIXEL, 32'hFFFF_FFFF, 1'b0, none);
    plan_item(FUNC_FLUSH, 32'h0000_0000, 1'b0, none);
    plan_item(FUNC_FLUSH, 32'h0000_0000, 1'b1, lone_pixel(255, 255, 255, 255, 1'b0));
    // small 3x2 frame with hard edges, predicted
    plan_cfg(CFG_EDGE_THRESHOLD, 32);
    plan_cfg(CFG_EDGE_FLOOR, 8);
    plan_cfg(CFG_FRAME_WIDTH, 3);
    plan_cfg(CFG_FRAME_HEIGHT, 2);
    plan_item(FUNC_PIXEL, 32'h0000_00FF, 1'b0, none);
    plan_item(FUNC_PIXEL, 32'hFF00_FF00, 1'b0, none);
    plan_item(FUNC_PIXEL, 32'h80FF_0000, 1'b0, none);
    plan_item(FUNC_PIXEL, 32'h00FF_FFFF, 1'b0, none);
    plan_item(FUNC_PIXEL, 32'h0A0A_0A0A, 1'b0, none);
    plan_item(FUNC_PIXEL, 32'hFF20_4080, 1'b0, none);
    repeat (4) plan_item(FUNC_FLUSH, 32'h0000_0000, 1'b0, none);

    // reset
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        settle();
        write_reg(directed_plan[i].idx, directed_plan[i].data);
      end else begin
        send_item(directed_plan[i].func, directed_plan[i].px, directed_plan[i].typed,
                  directed_plan[i].want);
      end
    end

    // random small frames, leaving room for the closing frames
    while (items_counted + TAIL_ITEMS < ITEM_TARGET) begin
      settle();
      program_regs(
        CFG_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 96) : $urandom_range(0, 511)),
        CFG_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 40) : $urandom_range(0, 255)),
        CFG_W'(($urandom_range(0, 4) != 0) ? $urandom_range(1, 10) : $urandom_range(11, 40)),
        CFG_W'($urandom_range(1, 6)));
      send_frame(1'b0);
    end

    // wide frame with the long hold-off, 1x24 frame, zero sizes that clamp to one
    settle();
    program_regs(256, 0, 60, 1);
    send_frame(1'b1);
    settle();
    program_regs(0, 255, 1, 24);
    send_frame(1'b0);
    settle();
    program_regs(511, 128, 0, 0);
    send_frame(1'b0);
    settle();

    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("diagonal_luma_edge_blend_filter regression: pass");
    end else begin
      $display("diagonal_luma_edge_blend_filter regression: fail");
    end
    $finish;
  end

endmodule
